/* rtl/source_switch_state_tracker_assert.svh */
// Assertion macros for the source switch state tracker.
// Used by the port checker; depends on nothing else.
`ifndef SOURCE_SWITCH_STATE_TRACKER_ASSERT_SVH
`define SOURCE_SWITCH_STATE_TRACKER_ASSERT_SVH

// same-cycle implication, reset masked
`define SST_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("sst check failed");

// next-cycle implication, reset masked
`define SST_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("sst check failed");

`endif

/* rtl/sst_pkg.sv */
// Shared types, codes and sizes for the source switch state tracker.
// No dependencies.
package sst_pkg;

    localparam int PENDING_DEPTH = 8;
    localparam int ID_BITS       = 16;
    localparam int GROUP_ID_BITS = 16;
    // compared ID bits: the port carries GROUP_ID_BITS, higher bits read as zero
    localparam int KEY_BITS = (ID_BITS < GROUP_ID_BITS) ? ID_BITS : GROUP_ID_BITS;
    localparam int POLL_BITS  = 8;
    localparam int STATE_BITS = 3;
    localparam int FUNC_BITS  = 2;
    localparam int CMD_BITS   = 2;

    localparam logic [FUNC_BITS-1:0] FN_SWITCH = 2'd0;
    localparam logic [FUNC_BITS-1:0] FN_QUERY  = 2'd1;
    localparam logic [FUNC_BITS-1:0] FN_RESP   = 2'd2;

    localparam logic [STATE_BITS-1:0] DS_UNDEFINED = 3'd0;
    localparam logic [STATE_BITS-1:0] DS_IDLE      = 3'd1;
    localparam logic [STATE_BITS-1:0] DS_BUSY      = 3'd2;
    localparam logic [STATE_BITS-1:0] DS_ERR_SW    = 3'd3;
    localparam logic [STATE_BITS-1:0] DS_ERR_POLL  = 3'd4;

    localparam logic [CMD_BITS-1:0] PC_NONE  = 2'd0;
    localparam logic [CMD_BITS-1:0] PC_START = 2'd1;
    localparam logic [CMD_BITS-1:0] PC_STOP  = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic load;   // capture the input transaction
        logic look;   // register table match / free vectors
        logic apply;  // update tables and state, load the result register
    } sst_cmd_t;

    function automatic logic is_err_state(input logic [STATE_BITS-1:0] s);
        return (s == DS_ERR_SW) || (s == DS_ERR_POLL);
    endfunction

endpackage

/* rtl/source_switch_state_tracker.sv */
// Top level of the source switch state tracker.
// Depends on sst_pkg, sst_ctrl and sst_datapath.
//
// Usage
//   Input channel s_*: one event transaction per handshake (s_valid & s_ready):
//   switch start, state-query start or response, with its group ID and the
//   response pass flag. Result channel m_*: exactly one result transaction per
//   input, in order, carrying the device state after the event, whether it
//   changed, the poller command, the error flag and the table-full flag.
//   cfg_we / cfg_wdata write the clean-poll count used after a switch; write
//   it only while no transaction is in flight.
// Timing
//   The sequencer holds one transaction at a time: capture, table compare (all
//   entries in parallel), then state update, which loads the result register
//   and raises m_valid. A new input is taken in the update cycle, so the next
//   transaction is captured while the last one is applied.
// Reset (aresetn, synchronous, active low)
//   Both pending tables empty, state undefined, countdown and poll count zero.
// Back-pressure
//   A result waits in the output register while m_ready is low; the next input
//   may be accepted and looked up, but its update stalls until the result
//   register is free, and s_ready stays low meanwhile.
module source_switch_state_tracker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [sst_pkg::FUNC_BITS-1:0]       s_func,
    input  logic [sst_pkg::GROUP_ID_BITS-1:0]   s_group_id,
    input  logic                                s_passed_all,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [sst_pkg::STATE_BITS-1:0]      m_cur_state,
    output logic                                m_state_changed,
    output logic [sst_pkg::CMD_BITS-1:0]        m_poll_command,
    output logic                                m_is_error,
    output logic                                m_table_full,
    input  logic                                cfg_we,
    input  logic [sst_pkg::POLL_BITS-1:0]       cfg_wdata
);
    import sst_pkg::*;

    sst_cmd_t cmd;

    // sequencing and handshakes
    sst_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // tables, state and result register
    sst_datapath u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .in_func           (s_func),
        .in_group_id       (s_group_id),
        .in_passed_all     (s_passed_all),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .out_cur_state     (m_cur_state),
        .out_state_changed (m_state_changed),
        .out_poll_command  (m_poll_command),
        .out_is_error      (m_is_error),
        .out_table_full    (m_table_full)
    );

endmodule

/* rtl/sst_ctrl.sv */
// Sequencer for the source switch state tracker: capture, look-up, apply.
// Depends on sst_pkg.
module sst_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output sst_pkg::sst_cmd_t cmd
);
    import sst_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_LOOK  = 2'd1;
    localparam logic [1:0] ST_APPLY = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       mvalid_reg, mvalid_next;
    logic       out_free, accept, apply_go;

    assign out_free = !mvalid_reg || m_ready;
    assign apply_go = (state_reg == ST_APPLY) && out_free;
    assign s_ready  = (state_reg == ST_IDLE) || apply_go;
    assign accept   = s_valid && s_ready;
    assign m_valid  = mvalid_reg;

    assign cmd.load  = accept;
    assign cmd.look  = (state_reg == ST_LOOK);
    assign cmd.apply = apply_go;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) state_next = ST_LOOK;
            end
            ST_LOOK: begin
                state_next = ST_APPLY;
            end
            ST_APPLY: begin
                if (apply_go) state_next = accept ? ST_LOOK : ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        mvalid_next = mvalid_reg;
        if (apply_go)     mvalid_next = 1'b1;
        else if (m_ready) mvalid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

endmodule

/* rtl/sst_datapath.sv */
// Datapath: pending-ID tables, device state, poll countdown, result register.
// Depends on sst_pkg.
module sst_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  sst_pkg::sst_cmd_t                   cmd,
    input  logic [sst_pkg::FUNC_BITS-1:0]       in_func,
    input  logic [sst_pkg::GROUP_ID_BITS-1:0]   in_group_id,
    input  logic                                in_passed_all,
    input  logic                                cfg_we,
    input  logic [sst_pkg::POLL_BITS-1:0]       cfg_wdata,
    output logic [sst_pkg::STATE_BITS-1:0]      out_cur_state,
    output logic                                out_state_changed,
    output logic [sst_pkg::CMD_BITS-1:0]        out_poll_command,
    output logic                                out_is_error,
    output logic                                out_table_full
);
    import sst_pkg::*;

    // captured transaction
    logic [FUNC_BITS-1:0] func_reg;
    logic [KEY_BITS-1:0]  id_reg;
    logic                 pass_reg;

    // tables
    logic [PENDING_DEPTH-1:0] sw_valid_reg, sw_valid_next;
    logic [PENDING_DEPTH-1:0] q_valid_reg, q_valid_next;
    logic [KEY_BITS-1:0]      sw_id_reg [PENDING_DEPTH];
    logic [KEY_BITS-1:0]      q_id_reg  [PENDING_DEPTH];
    logic [PENDING_DEPTH-1:0] sw_wr, q_wr;

    // look-up results
    logic [PENDING_DEPTH-1:0] sw_match, q_match, sw_inv, q_inv;
    logic [PENDING_DEPTH-1:0] sw_match_reg, q_match_reg, sw_free_reg, q_free_reg;

    logic [POLL_BITS-1:0]  poll_cfg_reg;
    logic [STATE_BITS-1:0] state_reg, state_next;
    logic [POLL_BITS-1:0]  cd_reg, cd_next;
    logic                  chg, full;
    logic [CMD_BITS-1:0]   pcmd;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg <= in_func;
            id_reg   <= in_group_id[KEY_BITS-1:0];
            pass_reg <= in_passed_all;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < PENDING_DEPTH; gi++) begin : g_cmp
            assign sw_match[gi] = sw_valid_reg[gi] && (sw_id_reg[gi] == id_reg);
            assign q_match[gi]  = q_valid_reg[gi]  && (q_id_reg[gi]  == id_reg);

            always_ff @(posedge aclk) begin
                if (sw_wr[gi]) sw_id_reg[gi] <= id_reg;
                if (q_wr[gi])  q_id_reg[gi]  <= id_reg;
            end
        end
    endgenerate

    assign sw_inv = ~sw_valid_reg;
    assign q_inv  = ~q_valid_reg;

    // registered match vectors, and the lowest free slot as a one-hot vector
    always_ff @(posedge aclk) begin
        if (cmd.look) begin
            sw_match_reg <= sw_match;
            q_match_reg  <= q_match;
            sw_free_reg  <= sw_inv & (~sw_inv + PENDING_DEPTH'(1));
            q_free_reg   <= q_inv  & (~q_inv  + PENDING_DEPTH'(1));
        end
    end

    always_comb begin
        sw_valid_next = sw_valid_reg;
        q_valid_next  = q_valid_reg;
        sw_wr         = '0;
        q_wr          = '0;
        state_next    = state_reg;
        cd_next       = cd_reg;
        chg           = 1'b0;
        pcmd          = PC_NONE;
        full          = 1'b0;
        case (func_reg)
            FN_SWITCH: begin
                if (sw_match_reg == '0) begin
                    if (sw_free_reg == '0) full = 1'b1;
                    else                   sw_wr = sw_free_reg;
                end
                if (state_next != DS_BUSY) begin
                    state_next = DS_BUSY;
                    chg        = 1'b1;
                    pcmd       = PC_START;
                end
            end
            FN_QUERY: begin
                if (q_match_reg == '0) begin
                    if (q_free_reg == '0) full = 1'b1;
                    else                  q_wr = q_free_reg;
                end
            end
            FN_RESP: begin
                // switch rule
                sw_valid_next = sw_valid_reg & ~sw_match_reg;
                if (sw_match_reg != '0) begin
                    if (!pass_reg && !is_err_state(state_next)) begin
                        state_next = DS_ERR_SW;
                        chg        = 1'b1;
                        pcmd       = PC_STOP;
                    end else if (state_next == DS_BUSY) begin
                        if (poll_cfg_reg != '0) begin
                            cd_next = poll_cfg_reg;
                            pcmd    = PC_START;
                        end else begin
                            state_next = DS_IDLE;
                            chg        = 1'b1;
                            pcmd       = PC_START;
                        end
                    end
                end
                // query rule, on the state the switch rule left
                q_valid_next = q_valid_reg & ~q_match_reg;
                if (q_match_reg != '0) begin
                    if (cd_next != '0) begin
                        cd_next = cd_next - POLL_BITS'(1);
                        if (!pass_reg && !is_err_state(state_next)) begin
                            if (state_next != DS_ERR_SW) begin
                                state_next = DS_ERR_SW;
                                chg        = 1'b1;
                                pcmd       = PC_STOP;
                            end
                            cd_next = '0;
                        end else if (cd_next == '0) begin
                            if (state_next != DS_IDLE) begin
                                state_next = DS_IDLE;
                                chg        = 1'b1;
                                pcmd       = PC_START;
                            end
                        end
                    end else if (!pass_reg && !is_err_state(state_next)) begin
                        state_next = DS_ERR_POLL;
                        chg        = 1'b1;
                        pcmd       = PC_STOP;
                    end else if (state_next == DS_UNDEFINED) begin
                        state_next = DS_IDLE;
                        chg        = 1'b1;
                        pcmd       = PC_START;
                    end
                end
            end
            default: begin
                // unused code: nothing changes
            end
        endcase
        if (!cmd.apply) begin
            sw_wr = '0;
            q_wr  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sw_valid_reg <= '0;
            q_valid_reg  <= '0;
            state_reg    <= DS_UNDEFINED;
            cd_reg       <= '0;
            poll_cfg_reg <= '0;
        end else begin
            if (cfg_we) poll_cfg_reg <= cfg_wdata;
            if (cmd.apply) begin
                sw_valid_reg <= sw_valid_next | sw_wr;
                q_valid_reg  <= q_valid_next | q_wr;
                state_reg    <= state_next;
                cd_reg       <= cd_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.apply) begin
            out_cur_state     <= state_next;
            out_state_changed <= chg;
            out_poll_command  <= pcmd;
            out_is_error      <= is_err_state(state_next);
            out_table_full    <= full;
        end
    end

endmodule

/* rtl/sst_checker.sv */
// Port-level checker for the source switch state tracker, with its bind.
// Depends on sst_pkg and source_switch_state_tracker_assert.svh.
`include "source_switch_state_tracker_assert.svh"

module sst_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic                                m_valid,
    input logic [sst_pkg::STATE_BITS-1:0]      m_cur_state,
    input logic                                m_state_changed,
    input logic [sst_pkg::CMD_BITS-1:0]        m_poll_command,
    input logic                                m_is_error
);
    import sst_pkg::*;

    // error flag follows the reported state
    `SST_ASSERT_IMPLY(a_err_flag, aclk, aresetn, m_valid, m_is_error == ((m_cur_state == DS_ERR_SW) || (m_cur_state == DS_ERR_POLL)))
    // stop is only issued on a change into an error state
    `SST_ASSERT_IMPLY(a_stop_err, aclk, aresetn, m_valid && (m_poll_command == PC_STOP), m_is_error && m_state_changed)
    // a change into a non-error state always restarts the poller
    `SST_ASSERT_IMPLY(a_chg_start, aclk, aresetn, m_valid && m_state_changed && !m_is_error, m_poll_command == PC_START)
    // one transaction in the sequencer: no back-to-back acceptance
    `SST_ASSERT_NEXT(a_one_flight, aclk, aresetn, s_valid && s_ready, !s_ready)

endmodule

bind source_switch_state_tracker sst_checker u_sst_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_cur_state     (m_cur_state),
    .m_state_changed (m_state_changed),
    .m_poll_command  (m_poll_command),
    .m_is_error      (m_is_error)
);

/* tb/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for source_switch_state_tracker: event transactions in,
// device status out, checked against an in-bench model of the tracker.
// Depends on sst_pkg and the tracker RTL only.
module tb;

    import sst_pkg::*;

    // func code with no meaning in the block; must change nothing
    localparam logic [FUNC_BITS-1:0] FN_UNUSED = 2'd3;

    localparam int TBL_SWITCH   = 0;
    localparam int TBL_QUERY    = 1;
    localparam int POOL_SIZE    = 12;     // > PENDING_DEPTH so the tables can overflow
    localparam int DRAIN_CYCLES = 8;      // idle cycles added once every result is back, as slack
    localparam int QUIET_LIMIT  = 5000;   // cycles with no transaction on either side
    localparam int REPORT_MAX   = 10;
    localparam int LONG_HOLD    = 200;

    // one status transaction as the block presents it
    typedef struct packed {
        logic [STATE_BITS-1:0] state;
        logic                  changed;
        logic [CMD_BITS-1:0]   cmd;
        logic                  fault;
        logic                  full;
    } tracker_status_t;

    logic                     aclk            = 1'b0;
    logic                     aresetn         = 1'b0;
    logic                     s_valid         = 1'b0;
    logic                     s_ready;
    logic [FUNC_BITS-1:0]     s_func          = FN_SWITCH;
    logic [GROUP_ID_BITS-1:0] s_group_id      = '0;
    logic                     s_passed_all    = 1'b0;
    logic                     m_valid;
    logic                     m_ready         = 1'b0;
    logic [STATE_BITS-1:0]    m_cur_state;
    logic                     m_state_changed;
    logic [CMD_BITS-1:0]      m_poll_command;
    logic                     m_is_error;
    logic                     m_table_full;
    logic                     cfg_we          = 1'b0;
    logic [POLL_BITS-1:0]     cfg_wdata       = '0;

    source_switch_state_tracker i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_group_id      (s_group_id),
        .s_passed_all    (s_passed_all),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_cur_state     (m_cur_state),
        .m_state_changed (m_state_changed),
        .m_poll_command  (m_poll_command),
        .m_is_error      (m_is_error),
        .m_table_full    (m_table_full),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Tracker model: own copy of the pending tables, state, countdown and
    // the poll-count register. Updated once per accepted input transaction.
    // ------------------------------------------------------------------
    logic                  pend_valid [2][PENDING_DEPTH];
    logic [KEY_BITS-1:0]   pend_id    [2][PENDING_DEPTH];
    logic [STATE_BITS-1:0] dev_state;
    logic [POLL_BITS-1:0]  polls_left;
    logic [POLL_BITS-1:0]  poll_setting;
    logic                  step_changed;
    logic [CMD_BITS-1:0]   step_cmd;

    tracker_status_t expected_status[$];

    int  fail_count  = 0;
    int  events_sent = 0;
    bit  idle_en     = 1'b1;   // random gaps on both channels
    int  hold_req    = 0;      // long receiver hold-off, picked up by the sink
    int  quiet_cycles = 0;
    logic [GROUP_ID_BITS-1:0] id_pool[POOL_SIZE];

    function automatic void clear_model();
        int i;
        for (i = 0; i < PENDING_DEPTH; i++) begin
            pend_valid[TBL_SWITCH][i] = 1'b0;
            pend_valid[TBL_QUERY][i]  = 1'b0;
            pend_id[TBL_SWITCH][i]    = '0;
            pend_id[TBL_QUERY][i]     = '0;
        end
        dev_state    = DS_UNDEFINED;
        polls_left   = '0;
        poll_setting = '0;
    endfunction

    function automatic logic fault_state();
        return (dev_state == DS_ERR_SW) || (dev_state == DS_ERR_POLL);
    endfunction

    // a real transition sets the changed flag and asks the poller to start,
    // or to stop if we have just gone into an error state
    function automatic void enter_state(input logic [STATE_BITS-1:0] nxt);
        if (dev_state != nxt) begin
            dev_state    = nxt;
            step_changed = 1'b1;
            step_cmd     = fault_state() ? PC_STOP : PC_START;
        end
    endfunction

    // returns 1 when the ID had to be dropped (table full)
    function automatic logic tbl_claim(input int t, input logic [KEY_BITS-1:0] key);
        int i;
        int free_slot;
        free_slot = -1;
        for (i = 0; i < PENDING_DEPTH; i++) begin
            if (pend_valid[t][i] && pend_id[t][i] == key)
                return 1'b0;
            if (!pend_valid[t][i] && free_slot < 0)
                free_slot = i;
        end
        if (free_slot < 0)
            return 1'b1;
        pend_valid[t][free_slot] = 1'b1;
        pend_id[t][free_slot]    = key;
        return 1'b0;
    endfunction

    function automatic logic tbl_release(input int t, input logic [KEY_BITS-1:0] key);
        int i;
        logic hit;
        hit = 1'b0;
        for (i = 0; i < PENDING_DEPTH; i++) begin
            if (pend_valid[t][i] && pend_id[t][i] == key) begin
                pend_valid[t][i] = 1'b0;
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic tracker_status_t predict_status(input logic [FUNC_BITS-1:0] fn,
                                                       input logic [GROUP_ID_BITS-1:0] gid,
                                                       input logic pass);
        tracker_status_t r;
        logic [KEY_BITS-1:0] key;
        logic dropped;
        key          = gid[KEY_BITS-1:0];
        dropped      = 1'b0;
        step_changed = 1'b0;
        step_cmd     = PC_NONE;
        case (fn)
            FN_SWITCH: begin
                dropped = tbl_claim(TBL_SWITCH, key);
                enter_state(DS_BUSY);
            end
            FN_QUERY: begin
                dropped = tbl_claim(TBL_QUERY, key);
            end
            FN_RESP: begin
                // switch rule first, then the query rule on the same response
                if (tbl_release(TBL_SWITCH, key)) begin
                    if (!pass && !fault_state()) begin
                        enter_state(DS_ERR_SW);
                    end else if (dev_state == DS_BUSY) begin
                        if (poll_setting != 0) begin
                            polls_left = poll_setting;
                            step_cmd   = PC_START;
                        end else begin
                            enter_state(DS_IDLE);
                        end
                    end
                end
                if (tbl_release(TBL_QUERY, key)) begin
                    if (polls_left != 0) begin
                        polls_left = polls_left - 1'b1;
                        if (!pass && !fault_state()) begin
                            enter_state(DS_ERR_SW);
                            polls_left = '0;
                        end else if (polls_left == 0) begin
                            enter_state(DS_IDLE);
                        end
                    end else if (!pass && !fault_state()) begin
                        enter_state(DS_ERR_POLL);
                    end else if (dev_state == DS_UNDEFINED) begin
                        enter_state(DS_IDLE);
                    end
                end
            end
            default: begin
            end
        endcase
        r.state   = dev_state;
        r.changed = step_changed;
        r.cmd     = step_cmd;
        r.fault   = fault_state();
        r.full    = dropped;
        return r;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        if (!idle_en)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // ------------------------------------------------------------------
    // Source side: one event transaction per call, held until accepted.
    // Called just after a rising edge; the expectation is queued at the
    // accepting edge, well ahead of the result.
    // ------------------------------------------------------------------
    task automatic send_event(input logic [FUNC_BITS-1:0] fn,
                              input logic [GROUP_ID_BITS-1:0] gid,
                              input logic pass);
        int gap;
        s_valid      <= 1'b1;
        s_func       <= fn;
        s_group_id   <= gid;
        s_passed_all <= pass;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        expected_status.push_back(predict_status(fn, gid, pass));
        events_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // stop offering, let every expected result come back, then a few idle cycles
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_status.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // register write, only ever with the block idle
    task automatic write_poll_count(input logic [POLL_BITS-1:0] v);
        wait_drained();
        cfg_we       <= 1'b1;
        cfg_wdata    <= v;
        poll_setting = v;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sink side: random ready with its own hold-off counter, and the
    // in-order check of every accepted status transaction.
    // ------------------------------------------------------------------
    task automatic check_status();
        tracker_status_t want;
        tracker_status_t got;
        got = {m_cur_state, m_state_changed, m_poll_command, m_is_error, m_table_full};
        if (expected_status.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
                $display("%0t: status transaction with none expected (state %0d)",
                         $realtime, got.state);
        end else begin
            want = expected_status.pop_front();
            if (got.state !== want.state || got.changed !== want.changed ||
                got.cmd !== want.cmd || got.fault !== want.fault ||
                got.full !== want.full) begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                    $display("%0t: state %0d/%0d changed %0d/%0d cmd %0d/%0d err %0d/%0d full %0d/%0d (exp/got)",
                             $realtime, want.state, got.state, want.changed, got.changed,
                             want.cmd, got.cmd, want.fault, got.fault, want.full, got.full);
            end
        end
    endtask

    int rx_wait = 0;

    always @(posedge aclk) begin
        int gap;
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (m_valid && m_ready)
                check_status();
            if (hold_req > 0) begin
                rx_wait  = hold_req;
                hold_req = 0;
            end
            if (rx_wait > 0) begin
                rx_wait = rx_wait - 1;
                m_ready <= 1'b0;
            end else begin
                gap = pick_gap();
                if (gap == 0) begin
                    m_ready <= 1'b1;
                end else begin
                    m_ready <= 1'b0;
                    rx_wait = gap - 1;
                end
            end
        end
    end

    // watchdog: too long without any transaction on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("source_switch_state_tracker: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Random stimulus helpers
    // ------------------------------------------------------------------
    task automatic refresh_pool();
        int i;
        for (i = 0; i < POOL_SIZE; i++)
            id_pool[i] = GROUP_ID_BITS'($urandom_range(0, 16'hFFFF));
    endtask

    function automatic logic [GROUP_ID_BITS-1:0] pick_id();
        if ($urandom_range(0, 9) == 0)
            return GROUP_ID_BITS'($urandom_range(0, 16'hFFFF));
        return id_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    // a well-formed switch: start, a few outstanding queries, the switch
    // response, the confirming poll transactions, then the early query answers
    task automatic run_switch_episode();
        logic [GROUP_ID_BITS-1:0] sw_id;
        logic [GROUP_ID_BITS-1:0] q_id;
        logic [GROUP_ID_BITS-1:0] early[$];
        int n_early;
        int n_polls;
        int i;
        sw_id   = pick_id();
        n_early = $urandom_range(0, 3);
        send_event(FN_SWITCH, sw_id, 1'($urandom_range(0, 1)));
        for (i = 0; i < n_early; i++) begin
            q_id = pick_id();
            early.push_back(q_id);
            send_event(FN_QUERY, q_id, 1'($urandom_range(0, 1)));
        end
        send_event(FN_RESP, sw_id, $urandom_range(0, 9) != 0);
        if (poll_setting <= 12)
            n_polls = poll_setting + $urandom_range(0, 1);
        else
            n_polls = $urandom_range(1, 8);
        for (i = 0; i < n_polls; i++) begin
            q_id = pick_id();
            send_event(FN_QUERY, q_id, 1'($urandom_range(0, 1)));
            send_event(FN_RESP, q_id, $urandom_range(0, 19) != 0);
        end
        while (early.size() != 0)
            send_event(FN_RESP, early.pop_front(), $urandom_range(0, 9) != 0);
    endtask

    // noise: any func code including the unused one, stray and repeated IDs
    task automatic run_noise_burst();
        int n;
        int i;
        n = $urandom_range(1, 4);
        for (i = 0; i < n; i++)
            send_event(FUNC_BITS'($urandom_range(0, 3)), pick_id(),
                       1'($urandom_range(0, 1)));
    endtask

    task automatic run_random_phase(input int quota);
        int stop_at;
        stop_at = events_sent + quota;
        refresh_pool();
        while (events_sent < stop_at) begin
            if ($urandom_range(0, 9) < 7)
                run_switch_episode();
            else
                run_noise_burst();
        end
    endtask

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    // from undefined: stray response and unused code do nothing, a clean
    // query answer moves the device to idle
    task automatic test_idle_entry();
        send_event(FN_RESP,   16'h1234, 1'b1);
        send_event(FN_UNUSED, 16'hFFFF, 1'b1);
        send_event(FN_QUERY,  16'h0000, 1'b1);
        send_event(FN_RESP,   16'h0000, 1'b1);
    endtask

    // switch success with no polls, a repeated start, a failed switch, a failed
    // poll while already in error, and a fresh switch out of the error
    task automatic test_switch_outcomes();
        send_event(FN_SWITCH, 16'hFFFF, 1'b0);
        send_event(FN_SWITCH, 16'hFFFF, 1'b1);
        send_event(FN_RESP,   16'hFFFF, 1'b1);
        send_event(FN_SWITCH, 16'h8001, 1'b1);
        send_event(FN_RESP,   16'h8001, 1'b0);
        send_event(FN_QUERY,  16'h7FFE, 1'b0);
        send_event(FN_RESP,   16'h7FFE, 1'b0);
        send_event(FN_SWITCH, 16'h5555, 1'b0);
    endtask

    // fill the query table, the ninth ID is dropped
    task automatic test_query_table_full();
        int i;
        for (i = 0; i < PENDING_DEPTH + 1; i++)
            send_event(FN_QUERY, GROUP_ID_BITS'(16'h00A0 + i), 1'b0);
    endtask

    // countdown of two: switch success loads it, one clean poll, then a
    // response held in both tables fails the switch and finishes the count
    task automatic test_poll_countdown();
        write_poll_count(8'd2);
        send_event(FN_SWITCH, 16'h00A3, 1'b1);
        send_event(FN_RESP,   16'h5555, 1'b1);
        send_event(FN_RESP,   16'h00A0, 1'b1);
        send_event(FN_RESP,   16'h00A3, 1'b0);
    endtask

    // sink holds off for a long stretch while the source keeps offering
    task automatic test_backpressure();
        int stop_at;
        wait_drained();
        idle_en  = 1'b0;
        hold_req = LONG_HOLD;
        stop_at  = events_sent + 40;
        while (events_sent < stop_at)
            run_switch_episode();
        wait_drained();
        idle_en = 1'b1;
    endtask

    task automatic test_random();
        write_poll_count(8'd1);
        run_random_phase(450);
        write_poll_count(8'd0);
        run_random_phase(350);
        write_poll_count(8'd3);
        run_random_phase(350);
        // largest count, and a stretch with no idling on either side
        write_poll_count(8'd255);
        idle_en = 1'b0;
        run_random_phase(200);
        write_poll_count(POLL_BITS'($urandom_range(4, 12)));
        idle_en = 1'b1;
        run_random_phase(350);
    endtask

    initial begin
        clear_model();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_idle_entry();
        test_switch_outcomes();
        test_query_table_full();
        test_poll_countdown();
        test_backpressure();
        test_random();

        wait_drained();
        if (fail_count == 0 && expected_status.size() == 0)
            $display("source_switch_state_tracker: match");
        else
            $display("source_switch_state_tracker: mismatch");
        $finish;
    end

endmodule

/* source_switch_state_tracker.f */
+incdir+rtl
rtl/sst_pkg.sv
rtl/sst_ctrl.sv
rtl/sst_datapath.sv
rtl/source_switch_state_tracker.sv
rtl/sst_checker.sv
tb/tb.sv
